@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file of this block.
// Each macro expects a signal named clk, and all but AFA_ASSERT_NEXT_ALWAYS also rst_n, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define AFA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, inactive while reset is asserted.
`define AFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define AFA_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset behavior check failed");

`endif

@@ rtl/afa_pkg.sv @@
// ----------------------------------------------------------------------------
// afa_pkg
// Types and constants shared by the API frame assembler modules.
// ----------------------------------------------------------------------------
package afa_pkg;

  // Logical bytes that one item can produce before escaping.
  localparam int unsigned SlotCnt = 5;
  localparam int unsigned SlotIdxW = $clog2(SlotCnt);

  // Depth of the job queue between the front and the back end.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // Item kinds.
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DELIMITER = 2'd0;
  localparam logic [1:0] CFG_ESCAPE    = 2'd1;
  localparam logic [1:0] CFG_XON       = 2'd2;
  localparam logic [1:0] CFG_XOFF      = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] DELIMITER_RST = 8'h7E;
  localparam logic [7:0] ESCAPE_RST    = 8'h7D;
  localparam logic [7:0] XON_RST       = 8'h11;
  localparam logic [7:0] XOFF_RST      = 8'h13;

  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] SUM_BASE = 8'hFF;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] escape;
    logic [7:0] xon;
    logic [7:0] xoff;
  } cfg_t;

  // One queued job: the logical bytes of an item, which of them are subject
  // to escaping, the index of the last one and whether it closes the frame.
  typedef struct packed {
    logic [SlotCnt-1:0][7:0] bytes;
    logic [SlotCnt-1:0]      esc_en;
    logic [SlotIdxW-1:0]     last_idx;
    logic                    frame_end;
  } job_t;

endpackage

@@ rtl/afa_in_if.sv @@
// ----------------------------------------------------------------------------
// afa_in_if
// Input channel of the frame assembler: one header or payload item per handshake.
// ----------------------------------------------------------------------------
interface afa_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  api_id;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, command, api_id, payload_length, data_byte,
                  input ready);
  modport sink   (input valid, command, api_id, payload_length, data_byte,
                  output ready);
endinterface

@@ rtl/afa_out_if.sv @@
// ----------------------------------------------------------------------------
// afa_out_if
// Output channel of the frame assembler: one wire byte per handshake.
// ----------------------------------------------------------------------------
interface afa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, out_byte, frame_end, run_last, input ready);
  modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

@@ rtl/afa_front.sv @@
// ----------------------------------------------------------------------------
// afa_front
// Accepts items, tracks the open frame and builds one job per header item and per payload item of an open frame.
// ----------------------------------------------------------------------------
module afa_front (
  input  logic            clk,
  input  logic            rst_n,
  afa_in_if.sink          in_ch,
  input  afa_pkg::cfg_t   cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output afa_pkg::job_t   push_job
);

  logic [15:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic        frame_open_r, frame_open_nxt;

  logic [15:0] length_field;
  logic [15:0] remaining_dec;
  logic [7:0]  sum_new;
  logic        accept;

  assign in_ch.ready = push_ready;
  assign accept = in_ch.valid && push_ready;
  assign length_field = in_ch.payload_length + 16'd1;
  assign remaining_dec = bytes_remaining_r - 16'd1;
  assign sum_new = running_sum_r + in_ch.data_byte;

  always_comb begin
    push_valid = 1'b0;
    push_job = '0;
    bytes_remaining_nxt = bytes_remaining_r;
    running_sum_nxt = running_sum_r;
    frame_open_nxt = frame_open_r;
    if (accept) begin
      if (in_ch.command == afa_pkg::CMD_HEADER) begin
        push_valid = 1'b1;
        push_job.bytes[0] = cfg.delimiter;
        push_job.bytes[1] = length_field[15:8];
        push_job.bytes[2] = length_field[7:0];
        push_job.bytes[3] = in_ch.api_id;
        push_job.bytes[4] = afa_pkg::SUM_BASE - in_ch.api_id;
        // The delimiter itself goes out unescaped.
        push_job.esc_en = 5'b11110;
        running_sum_nxt = in_ch.api_id;
        if (in_ch.payload_length == 16'd0) begin
          push_job.last_idx = afa_pkg::SlotIdxW'(4);
          push_job.frame_end = 1'b1;
          frame_open_nxt = 1'b0;
          bytes_remaining_nxt = 16'd0;
        end else begin
          push_job.last_idx = afa_pkg::SlotIdxW'(3);
          frame_open_nxt = 1'b1;
          bytes_remaining_nxt = in_ch.payload_length;
        end
      end else if (frame_open_r) begin
        push_valid = 1'b1;
        push_job.bytes[0] = in_ch.data_byte;
        push_job.bytes[1] = afa_pkg::SUM_BASE - sum_new;
        push_job.esc_en = 5'b00011;
        running_sum_nxt = sum_new;
        bytes_remaining_nxt = remaining_dec;
        if (remaining_dec == 16'd0) begin
          push_job.last_idx = afa_pkg::SlotIdxW'(1);
          push_job.frame_end = 1'b1;
          frame_open_nxt = 1'b0;
        end else begin
          push_job.last_idx = afa_pkg::SlotIdxW'(0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_remaining_r <= 16'd0;
      running_sum_r <= 8'd0;
      frame_open_r <= 1'b0;
    end else begin
      bytes_remaining_r <= bytes_remaining_nxt;
      running_sum_r <= running_sum_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

@@ rtl/afa_queue.sv @@
// ----------------------------------------------------------------------------
// afa_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module afa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  afa_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output afa_pkg::job_t pop_job
);

  afa_pkg::job_t entry_r [afa_pkg::QueueDepth];

  logic [afa_pkg::QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [afa_pkg::QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [afa_pkg::QueueCntW-1:0] count_r, count_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (count_r != afa_pkg::QueueCntW'(afa_pkg::QueueDepth));
  assign pop_valid = (count_r != '0);
  assign pop_job = entry_r[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == afa_pkg::QueuePtrW'(afa_pkg::QueueDepth - 1)) ?
                   '0 : wr_ptr_r + afa_pkg::QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == afa_pkg::QueuePtrW'(afa_pkg::QueueDepth - 1)) ?
                   '0 : rd_ptr_r + afa_pkg::QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + afa_pkg::QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - afa_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/afa_back.sv @@
// ----------------------------------------------------------------------------
// afa_back
// Walks the current job, escapes its bytes and drives the output register.
// ----------------------------------------------------------------------------
module afa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  afa_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  afa_pkg::job_t pop_job,
  afa_out_if.source     out_ch
);

  afa_pkg::job_t                cur_r, cur_nxt;
  logic [afa_pkg::SlotIdxW-1:0] idx_r, idx_nxt;
  logic                         busy_r, busy_nxt;
  logic                         prefix_sent_r, prefix_sent_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_byte_r, out_byte_nxt;
  logic                         frame_end_r, frame_end_nxt;
  logic                         run_last_r, run_last_nxt;

  logic [7:0] cur_byte;
  logic       is_special;
  logic       need_escape;
  logic       at_last;
  logic       advance;

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.frame_end = frame_end_r;
  assign out_ch.run_last = run_last_r;

  assign advance = !out_valid_r || out_ch.ready;
  assign cur_byte = cur_r.bytes[idx_r];
  assign is_special = (cur_byte == cfg.delimiter) || (cur_byte == cfg.escape) ||
                      (cur_byte == cfg.xon) || (cur_byte == cfg.xoff);
  assign need_escape = cur_r.esc_en[idx_r] && is_special;
  assign at_last = (idx_r == cur_r.last_idx);

  always_comb begin
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    busy_nxt = busy_r;
    prefix_sent_nxt = prefix_sent_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt = out_byte_r;
    frame_end_nxt = frame_end_r;
    run_last_nxt = run_last_r;
    pop_ready = 1'b0;
    if (busy_r) begin
      if (advance) begin
        out_valid_nxt = 1'b1;
        if (need_escape && !prefix_sent_r) begin
          out_byte_nxt = cfg.escape;
          frame_end_nxt = 1'b0;
          run_last_nxt = 1'b0;
          prefix_sent_nxt = 1'b1;
        end else begin
          out_byte_nxt = prefix_sent_r ? (cur_byte ^ afa_pkg::ESC_XOR) : cur_byte;
          frame_end_nxt = at_last && cur_r.frame_end;
          run_last_nxt = at_last;
          prefix_sent_nxt = 1'b0;
          if (at_last) begin
            // Chain straight into the next queued job to avoid a bubble.
            pop_ready = 1'b1;
            if (pop_valid) begin
              cur_nxt = pop_job;
              idx_nxt = '0;
            end else begin
              busy_nxt = 1'b0;
            end
          end else begin
            idx_nxt = idx_r + afa_pkg::SlotIdxW'(1);
          end
        end
      end
    end else begin
      if (advance) begin
        out_valid_nxt = 1'b0;
      end
      pop_ready = 1'b1;
      if (pop_valid) begin
        busy_nxt = 1'b1;
        cur_nxt = pop_job;
        idx_nxt = '0;
        prefix_sent_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    frame_end_r <= frame_end_nxt;
    run_last_r <= run_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
      prefix_sent_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r <= idx_nxt;
      prefix_sent_r <= prefix_sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/api_frame_assembler_top.sv @@
// ----------------------------------------------------------------------------
// api_frame_assembler_top
// Escaped API frame assembler: header and payload items in, wire bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items: a header item (command 0) opens a frame with api_id
//   and payload_length, a payload item (command 1) carries one data_byte.
//   out_ch carries one wire byte per handshake, with frame_end on the last
//   checksum byte and run_last on the last byte caused by an input item.
//   cfg_we/cfg_index/cfg_data write the delimiter, escape, XON and XOFF values;
//   write them only while the block is idle.
// Path: an accepted item goes into the job queue, then into the job register
//   of the back end, and its first wire byte then into the output register.
// Throughput: the back end emits one wire byte per cycle while out_ch.ready
//   is high. An item produces 1 to 9 wire bytes; a plain payload byte gives
//   one or two. A payload item with no frame open is taken and yields nothing.
// Reset: synchronous; it closes any frame, empties the two-entry job queue and
//   restores the default register values.
// Stall: when out_ch.ready is low the output byte holds; the job queue keeps
//   taking items until it fills, and then in_ch.ready drops.
module api_frame_assembler_top (
  input  logic       clk,
  input  logic       rst_n,
  afa_in_if.sink     in_ch,
  afa_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  afa_pkg::cfg_t cfg_r, cfg_nxt;
  afa_pkg::job_t push_job, pop_job;
  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        afa_pkg::CFG_DELIMITER: cfg_nxt.delimiter = cfg_data;
        afa_pkg::CFG_ESCAPE:    cfg_nxt.escape = cfg_data;
        afa_pkg::CFG_XON:       cfg_nxt.xon = cfg_data;
        afa_pkg::CFG_XOFF:      cfg_nxt.xoff = cfg_data;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter <= afa_pkg::DELIMITER_RST;
      cfg_r.escape <= afa_pkg::ESCAPE_RST;
      cfg_r.xon <= afa_pkg::XON_RST;
      cfg_r.xoff <= afa_pkg::XOFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  afa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  afa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  afa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/afa_checker.sv @@
// ----------------------------------------------------------------------------
// afa_checker
// Port-level checks on the result channel of the frame assembler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       frame_end,
  input logic       run_last
);

  // A pending byte stays offered until it is taken.
  `AFA_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid)

  // A stalled byte keeps its value and flags.
  `AFA_ASSERT_NEXT(a_out_payload_holds, out_valid && !out_ready,
                   $stable(out_byte) && $stable(frame_end) && $stable(run_last))

  // The checksum byte that closes a frame is always the last byte of its item.
  `AFA_ASSERT_IMPLIES(a_frame_end_is_run_last, out_valid && frame_end, run_last)

  // Nothing is offered in the cycle after reset.
  `AFA_ASSERT_NEXT_ALWAYS(a_idle_after_reset, !rst_n, !out_valid)

endmodule

bind api_frame_assembler_top afa_checker u_afa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .frame_end (out_ch.frame_end),
  .run_last  (out_ch.run_last)
);

@@ tb/afa_frame_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afa_frame_checker
// Watches the item and wire-byte channels of the frame assembler. It keeps its
// own copy of the escape registers and of the frame state, works out the wire
// bytes that each accepted item should produce, and checks every accepted wire
// byte against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module afa_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  afa_in_if          in_ch,
  afa_out_if         out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_cnt,
  output int         pending_cnt
);

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       frame_end;
    logic       run_last;
  } wire_item_t;

  afa_pkg::cfg_t regs;
  logic [15:0]   bytes_left;
  logic [7:0]    id_sum;
  logic          in_frame;

  wire_item_t  wire_q[$];
  wire_item_t  burst[9];
  int          burst_n;
  wire_item_t  want;
  int          bad_cnt;

  function automatic void put_raw(logic [7:0] b, logic fe);
    burst[burst_n] = '{wire_byte: b, frame_end: fe, run_last: 1'b0};
    burst_n++;
  endfunction

  function automatic void put_escaped(logic [7:0] b, logic fe);
    if (b == regs.delimiter || b == regs.escape || b == regs.xon || b == regs.xoff) begin
      put_raw(regs.escape, 1'b0);
      put_raw(b ^ afa_pkg::ESC_XOR, fe);
    end else begin
      put_raw(b, fe);
    end
  endfunction

  function automatic void put_checksum();
    put_escaped(afa_pkg::SUM_BASE - id_sum, 1'b1);
    in_frame   = 1'b0;
    bytes_left = '0;
  endfunction

  function automatic void assemble_item(logic cmd, logic [7:0] id, logic [15:0] len,
                                        logic [7:0] data);
    logic [15:0] len_field;
    burst_n = 0;
    if (cmd == afa_pkg::CMD_HEADER) begin
      // The length field counts the identifier too and wraps at 16 bits.
      len_field = len + 16'd1;
      put_raw(regs.delimiter, 1'b0);
      put_escaped(len_field[15:8], 1'b0);
      put_escaped(len_field[7:0], 1'b0);
      put_escaped(id, 1'b0);
      id_sum     = id;
      bytes_left = len;
      in_frame   = 1'b1;
      if (len == 16'd0) put_checksum();
    end else if (in_frame) begin
      put_escaped(data, 1'b0);
      id_sum     = id_sum + data;
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) put_checksum();
    end
    if (burst_n > 0) burst[burst_n-1].run_last = 1'b1;
    for (int i = 0; i < burst_n; i++) wire_q.push_back(burst[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs       = '{delimiter: afa_pkg::DELIMITER_RST, escape: afa_pkg::ESCAPE_RST,
                     xon: afa_pkg::XON_RST, xoff: afa_pkg::XOFF_RST};
      bytes_left = '0;
      id_sum     = '0;
      in_frame   = 1'b0;
      wire_q.delete();
      bad_cnt    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (wire_q.size() == 0) begin
          $error("wire byte %02h arrived with nothing outstanding", out_ch.out_byte);
          bad_cnt++;
        end else begin
          want = wire_q.pop_front();
          if (out_ch.out_byte !== want.wire_byte) begin
            $error("out_byte: expected %02h, got %02h", want.wire_byte, out_ch.out_byte);
            bad_cnt++;
          end
          if (out_ch.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_ch.frame_end);
            bad_cnt++;
          end
          if (out_ch.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
            bad_cnt++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          afa_pkg::CFG_DELIMITER: regs.delimiter = cfg_data;
          afa_pkg::CFG_ESCAPE:    regs.escape    = cfg_data;
          afa_pkg::CFG_XON:       regs.xon       = cfg_data;
          afa_pkg::CFG_XOFF:      regs.xoff      = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        assemble_item(in_ch.command, in_ch.api_id, in_ch.payload_length, in_ch.data_byte);
    end
    fail_cnt    <= bad_cnt;
    pending_cnt <= wire_q.size();
  end

endmodule

@@ tb/api_frame_assembler_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// api_frame_assembler_top_tb
// Drives header and payload items into the frame assembler under several
// escape register settings, with random gaps on the input and random stalls on
// the output, and reports the verdict of the frame checker.
// ----------------------------------------------------------------------------
module api_frame_assembler_top_tb;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [7:0]    cfg_data;
  int            fail_cnt;
  int            pending_cnt;
  int            in_gap_max;
  int            out_gap_max;
  int            sent_cnt;
  afa_pkg::cfg_t cur_cfg;

  afa_in_if  in_ch ();
  afa_out_if out_ch ();

  api_frame_assembler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  afa_frame_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Favors the values that the escape logic cares about.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return cur_cfg.delimiter;
      1: return cur_cfg.escape;
      2: return cur_cfg.xon;
      3: return cur_cfg.xoff;
      4: return cur_cfg.escape ^ afa_pkg::ESC_XOR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Leaves valid high after the handshake so that back-to-back items need no gap.
  task automatic send_item(input logic cmd, input logic [7:0] id, input logic [15:0] len,
                           input logic [7:0] data);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.api_id         <= id;
    in_ch.payload_length <= len;
    in_ch.data_byte      <= data;
    do @(posedge clk); while (!in_ch.ready);
    sent_cnt++;
  endtask

  task automatic send_payload(input logic [7:0] data);
    send_item(afa_pkg::CMD_PAYLOAD, 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)), data);
  endtask

  task automatic send_header(input logic [7:0] id, input logic [15:0] len);
    send_item(afa_pkg::CMD_HEADER, id, len, 8'($urandom_range(0, 255)));
  endtask

  // Holds the input until every outstanding wire byte has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input afa_pkg::cfg_t c);
    drain();
    put_reg(afa_pkg::CFG_DELIMITER, c.delimiter);
    put_reg(afa_pkg::CFG_ESCAPE, c.escape);
    put_reg(afa_pkg::CFG_XON, c.xon);
    put_reg(afa_pkg::CFG_XOFF, c.xoff);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_cfg = c;
  endtask

  task automatic run_random(input int quota);
    int start;
    int kind;
    int len;
    int cut;
    start = sent_cnt;
    while (sent_cnt - start < quota) begin
      in_gap_max  = ($urandom_range(0, 5) == 0) ? 0 : 4;
      out_gap_max = ($urandom_range(0, 5) == 0) ? 0 : 4;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        send_header(pick_byte(), 16'(len));
        for (int i = 0; i < len; i++) send_payload(pick_byte());
      end else if (kind < 85) begin
        // Frame cut short: the next header abandons it.
        len = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) : $urandom_range(2, 8);
        cut = $urandom_range(0, 4);
        if (len > 0 && cut >= len) cut = len - 1;
        send_header(pick_byte(), 16'(len));
        for (int i = 0; i < cut; i++) send_payload(pick_byte());
      end else if (kind < 95) begin
        // Usually lands with no frame open, so the block drops it.
        send_payload(pick_byte());
        sent_cnt--;
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = afa_pkg::CFG_DELIMITER;
    cfg_data             = 8'h00;
    in_ch.valid          = 1'b0;
    in_ch.command        = afa_pkg::CMD_HEADER;
    in_ch.api_id         = 8'h00;
    in_ch.payload_length = 16'h0000;
    in_ch.data_byte      = 8'h00;
    sent_cnt             = 0;
    in_gap_max           = 4;
    out_gap_max          = 4;
    cur_cfg = '{delimiter: afa_pkg::DELIMITER_RST, escape: afa_pkg::ESCAPE_RST,
                xon: afa_pkg::XON_RST, xoff: afa_pkg::XOFF_RST};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset register values.
    send_payload(8'hFF);
    send_header(8'h00, 16'h0000);
    send_header(8'hFF, 16'h0000);
    send_header(8'h81, 16'h0000);
    send_header(8'h7D, 16'h0001);
    send_payload(8'h7E);
    send_header(8'h11, 16'h0002);
    send_payload(8'h13);
    send_payload(8'h7D);
    send_header(8'h13, 16'h007D);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_header(8'hA5, 16'hFFFF);
    send_payload(8'h11);
    send_header(8'h5A, 16'hFFFE);
    send_payload(8'h20);
    send_header(8'h00, 16'h7CFF);
    send_payload(8'h7F);
    send_header(8'h20, 16'h0001);
    send_payload(8'h42);
    send_payload(8'h7E);

    // The sender waits here until the block has delivered everything.
    drain();
    run_random(80);

    set_config('{delimiter: 8'h00, escape: 8'hFF, xon: 8'h00, xoff: 8'hFF});
    send_header(8'hFF, 16'h0000);
    send_header(8'h00, 16'h00FF);
    send_payload(8'hFF);
    run_random(80);

    set_config('{delimiter: 8'hFF, escape: 8'h00, xon: 8'hFF, xoff: 8'h00});
    run_random(80);

    begin
      logic [7:0] same;
      same = 8'($urandom_range(0, 255));
      set_config('{delimiter: same, escape: same, xon: same, xoff: same});
    end
    run_random(80);

    set_config('{delimiter: 8'($urandom_range(0, 255)), escape: 8'($urandom_range(0, 255)),
                 xon: 8'($urandom_range(0, 255)), xoff: 8'($urandom_range(0, 255))});
    run_random(80);

    drain();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("api_frame_assembler_top: match");
    end else begin
      $display("api_frame_assembler_top: mismatch");
    end
    $finish;
  end

  // Output side: a random stall before each wire byte is taken.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    #2_000_000;
    $display("api_frame_assembler_top: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/afa_pkg.sv
rtl/afa_in_if.sv
rtl/afa_out_if.sv
rtl/afa_front.sv
rtl/afa_queue.sv
rtl/afa_back.sv
rtl/api_frame_assembler_top.sv
rtl/afa_checker.sv
tb/afa_frame_checker.sv
tb/api_frame_assembler_top_tb.sv
